>>> rtl/rletex_pkg.sv
// Shared types, constants and the colour widening function of the texture decoder.
`default_nettype none
package rletex_pkg;

   // Number of pixels in one image (128 x 128).
   localparam int unsigned IMAGE_PIXELS = 16384;
   // Width of the pixel counter, wide enough to hold IMAGE_PIXELS itself.
   localparam int unsigned PIX_W = $clog2(IMAGE_PIXELS + 1);
   localparam int unsigned WORD_W = 16;
   localparam int unsigned LIT_W = 9;
   localparam int unsigned RUN_W = 15;
   localparam int unsigned RGBA_W = 32;

   localparam logic [WORD_W-1:0] LITERAL_MASK = 16'hFF00;
   localparam logic [4:0] CHANNEL_MASK = 5'h1F;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [2:0] {
      PH_RAW     = 3'd0,
      PH_SIZE_LO = 3'd1,
      PH_SIZE_HI = 3'd2,
      PH_COUNT   = 3'd3,
      PH_LITERAL = 3'd4,
      PH_REPEAT  = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   // Word held in the input register.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
   } stage_type;

   // One decoded result.
   typedef struct packed {
      logic [RGBA_W-1:0] pixel_rgba;
      logic [RUN_W-1:0]  run_length;
      logic              image_done;
      logic              run_clamped;
   } result_type;

   // RGB555 to RGBA8888: each channel moves to the top of its byte, bit 15 is dropped.
   function automatic logic [RGBA_W-1:0] widen(input logic [WORD_W-1:0] w);
      logic [4:0] r;
      logic [4:0] g;
      logic [4:0] b;
      r = w[4:0] & CHANNEL_MASK;
      g = w[9:5] & CHANNEL_MASK;
      b = w[14:10] & CHANNEL_MASK;
      return {ALPHA_OPAQUE, b, 3'b000, g, 3'b000, r, 3'b000};
   endfunction

endpackage
`default_nettype wire

>>> rtl/rletex_in_stage.sv
// Input register of the texture decoder.
`default_nettype none
module rletex_in_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [rletex_pkg::WORD_W-1:0] req_tdata,
   input  wire logic                          advance,
   output rletex_pkg::stage_type              stage
);

   logic                          valid_ff;
   logic [rletex_pkg::WORD_W-1:0] word_ff;

   // The register may be refilled whenever it is empty or its word moves on.
   assign req_tready = !valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         word_ff <= req_tdata;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.word  = word_ff;

endmodule
`default_nettype wire

>>> rtl/rletex_parser.sv
// Parse state machine and result formation of the texture decoder.
`default_nettype none
module rletex_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_wdata,
   input  wire rletex_pkg::stage_type stage,
   input  wire logic                  advance,
   output logic                       load,
   output rletex_pkg::result_type     result
);

   rletex_pkg::phase_type            phase_ff, phase_in;
   logic [rletex_pkg::LIT_W-1:0]     literal_left_ff, literal_left_in;
   logic [rletex_pkg::WORD_W-1:0]    repeat_count_ff, repeat_count_in;
   logic [rletex_pkg::PIX_W-1:0]     pixels_done_ff, pixels_done_in;

   logic                             fire;
   logic                             emit;
   logic                             is_literal;
   logic [rletex_pkg::LIT_W-1:0]     literal_dec;
   logic [rletex_pkg::PIX_W-1:0]     remain;
   logic [rletex_pkg::PIX_W-1:0]     run;
   logic                             clamped;
   logic [rletex_pkg::PIX_W-1:0]     pixels_sum;
   logic                             done;

   assign fire        = stage.valid && advance;
   assign is_literal  = (stage.word & rletex_pkg::LITERAL_MASK) == rletex_pkg::LITERAL_MASK;
   assign literal_dec = literal_left_ff - 1'b1;
   assign remain      = rletex_pkg::PIX_W'(rletex_pkg::IMAGE_PIXELS) - pixels_done_ff;
   assign pixels_sum  = pixels_done_ff + run;
   assign done        = pixels_sum >= rletex_pkg::PIX_W'(rletex_pkg::IMAGE_PIXELS);

   // Output decode: which phases give a result and how long the run is.
   always_comb begin
      emit    = 1'b0;
      run     = '0;
      clamped = 1'b0;
      case (phase_ff)
         rletex_pkg::PH_RAW, rletex_pkg::PH_LITERAL: begin
            emit = 1'b1;
            run  = rletex_pkg::PIX_W'(1);
         end
         rletex_pkg::PH_REPEAT: begin
            emit = 1'b1;
            if (repeat_count_ff > rletex_pkg::WORD_W'(remain)) begin
               run     = remain;
               clamped = 1'b1;
            end else begin
               run = rletex_pkg::PIX_W'(repeat_count_ff);
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Next state of the parser.
   always_comb begin
      phase_in        = phase_ff;
      literal_left_in = literal_left_ff;
      repeat_count_in = repeat_count_ff;
      pixels_done_in  = pixels_done_ff;
      case (phase_ff)
         rletex_pkg::PH_RAW:     phase_in = rletex_pkg::PH_RAW;
         rletex_pkg::PH_SIZE_LO: phase_in = rletex_pkg::PH_SIZE_HI;
         rletex_pkg::PH_SIZE_HI: phase_in = rletex_pkg::PH_COUNT;
         rletex_pkg::PH_COUNT: begin
            if (is_literal) begin
               // A negative count announces that many literal pixels.
               literal_left_in = rletex_pkg::LIT_W'(17'h10000 - {1'b0, stage.word});
               phase_in        = rletex_pkg::PH_LITERAL;
            end else begin
               repeat_count_in = stage.word;
               phase_in        = rletex_pkg::PH_REPEAT;
            end
         end
         rletex_pkg::PH_LITERAL: begin
            literal_left_in = literal_dec;
            phase_in = (literal_dec == '0) ? rletex_pkg::PH_COUNT : rletex_pkg::PH_LITERAL;
         end
         rletex_pkg::PH_REPEAT: begin
            repeat_count_in = '0;
            phase_in        = rletex_pkg::PH_COUNT;
         end
         default: phase_in = rletex_pkg::PH_DONE;
      endcase
      if (emit) begin
         pixels_done_in = pixels_sum;
         if (done) begin
            phase_in = rletex_pkg::PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= rletex_pkg::PH_RAW;
         literal_left_ff <= '0;
         repeat_count_ff <= '0;
         pixels_done_ff  <= '0;
      end else if (csr_we) begin
         // A mode write restarts the image.
         phase_ff        <= csr_wdata ? rletex_pkg::PH_SIZE_LO : rletex_pkg::PH_RAW;
         literal_left_ff <= '0;
         repeat_count_ff <= '0;
         pixels_done_ff  <= '0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         literal_left_ff <= literal_left_in;
         repeat_count_ff <= repeat_count_in;
         pixels_done_ff  <= pixels_done_in;
      end
   end

   assign load               = fire && emit;
   assign result.pixel_rgba  = rletex_pkg::widen(stage.word);
   assign result.run_length  = rletex_pkg::RUN_W'(run);
   assign result.image_done  = done;
   assign result.run_clamped = clamped;

endmodule
`default_nettype wire

>>> rtl/rletex_out_reg.sv
// Result register of the texture decoder.
`default_nettype none
module rletex_out_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire rletex_pkg::result_type result,
   output logic                        advance,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output rletex_pkg::result_type      held
);

   logic                   valid_ff;
   rletex_pkg::result_type data_ff;

   // The register takes a new result when it is empty or being emptied this cycle.
   assign advance = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign held       = data_ff;

endmodule
`default_nettype wire

>>> rtl/rle_rgb555_texture_decoder.sv
// Top level of the run-length RGB555 texture decoder.
// A word enters the input register when it is accepted; its result is loaded into the
// result register once that register is empty or being emptied. Words that give no
// result leave nothing behind. Throughput: one word per cycle while results are taken,
// set by the single parse step between the two registers. Reset (synchronous, active
// high) selects raw mode, clears all counters and empties both registers; a mode write
// restarts the image in the written mode and clears the counters but not the registers.
`default_nettype none
module rle_rgb555_texture_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration: compressed_mode.
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,
   // Input words.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] data_word
   // Results.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [31:0] pixel_rgba, [46:32] run_length, [47] zero
   output logic             rsp_tlast,   // image_done
   output logic             rsp_tuser    // run_clamped
);

   rletex_pkg::stage_type  stage;
   rletex_pkg::result_type result;
   rletex_pkg::result_type held;
   logic                   advance;
   logic                   load;

   // The input register holds one word; it moves on whenever the result register can take
   // whatever that word produces, so both sides can stall independently.
   rletex_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .stage      (stage)
   );

   // The parser keeps the phase, the literal and repeat counts and the pixel counter, and
   // forms the widened colour and the clamped run length for the held word.
   rletex_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stage     (stage),
      .advance   (advance),
      .load      (load),
      .result    (result)
   );

   // The result register decouples the output from the parser.
   rletex_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .held       (held)
   );

   assign rsp_tdata = {1'b0, held.run_length, held.pixel_rgba};
   assign rsp_tlast = held.image_done;
   assign rsp_tuser = held.run_clamped;

endmodule
`default_nettype wire

>>> sim/rle_rgb555_texture_decoder_tb.sv
// Self-checking testbench for the run-length RGB555 texture decoder.
`timescale 1ns / 1ps
`default_nettype none
module rle_rgb555_texture_decoder_tb;

   // A stretch longer than this with no word moving on any port ends the run.
   localparam int unsigned STUCK_LIMIT = 2000;
   // The result register follows the input register, so this settle time is enough
   // for any word still in flight to leave both registers.
   localparam int unsigned SETTLE_CYCLES = 6;
   // The receiver holds off once, for this long, after this many words are taken.
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned HOLD_AT = 250;
   // Stop launching new random phases once this many words have been queued.
   localparam int unsigned WORD_TARGET = 710;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   rle_rgb555_texture_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [15:0] data_word
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // [31:0] pixel_rgba, [46:32] run_length, [47] zero
      .rsp_tlast  (rsp_tlast),     // image_done
      .rsp_tuser  (rsp_tuser)      // run_clamped
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Words waiting to be offered, and the texels the decoder still owes us.
   logic [15:0]            pending_words[$];
   rletex_pkg::result_type expected_texels[$];

   int unsigned words_issued = 0;
   int unsigned words_taken = 0;
   int unsigned mismatches = 0;
   int unsigned stuck_cycles = 0;
   int unsigned idle_pct = 22;
   int unsigned hold_left = 0;
   logic        hold_used = 1'b0;
   logic        req_fired = 1'b0;

   // Our own copy of the decoder state, kept in step with every accepted word.
   logic                  model_mode;
   rletex_pkg::phase_type model_phase;
   logic [8:0]            literal_left;
   logic [15:0]           pending_repeat;
   logic [14:0]           pixels_done;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Both reset and a mode write start a fresh image in the selected mode.
   task automatic restart_image();
      model_phase = model_mode ? rletex_pkg::PH_SIZE_LO : rletex_pkg::PH_RAW;
      literal_left = '0;
      pending_repeat = '0;
      pixels_done = '0;
   endtask

   // Advance the parse by one accepted word and queue the texel it yields, if any.
   task automatic decode_word(input logic [15:0] w);
      rletex_pkg::result_type texel;
      int unsigned            remain;
      int unsigned            run;
      int unsigned            total;
      int unsigned            lit;
      logic                   clamped;
      logic                   emits;
      emits = 1'b0;
      run = 1;
      clamped = 1'b0;
      case (model_phase)
         rletex_pkg::PH_RAW: begin
            emits = 1'b1;
         end
         rletex_pkg::PH_SIZE_LO: begin
            model_phase = rletex_pkg::PH_SIZE_HI;
         end
         rletex_pkg::PH_SIZE_HI: begin
            model_phase = rletex_pkg::PH_COUNT;
         end
         rletex_pkg::PH_COUNT: begin
            if ((w & rletex_pkg::LITERAL_MASK) == rletex_pkg::LITERAL_MASK) begin
               lit = 32'h10000 - 32'(w);
               literal_left = lit[8:0];
               model_phase = rletex_pkg::PH_LITERAL;
            end else begin
               pending_repeat = w;
               model_phase = rletex_pkg::PH_REPEAT;
            end
         end
         rletex_pkg::PH_LITERAL: begin
            literal_left = literal_left - 9'd1;
            model_phase = (literal_left == '0) ? rletex_pkg::PH_COUNT
                                               : rletex_pkg::PH_LITERAL;
            emits = 1'b1;
         end
         rletex_pkg::PH_REPEAT: begin
            remain = rletex_pkg::IMAGE_PIXELS - 32'(pixels_done);
            run = 32'(pending_repeat);
            if (run > remain) begin
               run = remain;
               clamped = 1'b1;
            end
            pending_repeat = '0;
            model_phase = rletex_pkg::PH_COUNT;
            emits = 1'b1;
         end
         default: ;
      endcase
      if (emits) begin
         total = 32'(pixels_done) + run;
         pixels_done = total[14:0];
         // Bit 15 is dropped; each five-bit channel moves to the top of its byte.
         texel.pixel_rgba = {8'hFF, w[14:10], 3'b000, w[9:5], 3'b000, w[4:0], 3'b000};
         texel.run_length = run[14:0];
         texel.image_done = (total >= rletex_pkg::IMAGE_PIXELS);
         texel.run_clamped = clamped;
         if (total >= rletex_pkg::IMAGE_PIXELS) begin
            model_phase = rletex_pkg::PH_DONE;
         end
         expected_texels.push_back(texel);
      end
   endtask

   // Everything is sampled at the rising edge: mode writes, accepted input words,
   // accepted results and the watchdog. Inputs only ever change at the falling edge.
   always @(posedge clock) begin
      if (reset) begin
         model_mode = 1'b0;
         restart_image();
         req_fired <= 1'b0;
         stuck_cycles <= 0;
      end else begin
         if (csr_we) begin
            model_mode = csr_wdata;
            restart_image();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_texels.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_tdata[31:0], '0);
            end else begin
               rletex_pkg::result_type want;
               want = expected_texels.pop_front();
               if (rsp_tdata[31:0] !== want.pixel_rgba)
                  report_mismatch("pixel_rgba", rsp_tdata[31:0], want.pixel_rgba);
               if (rsp_tdata[46:32] !== want.run_length)
                  report_mismatch("run_length", 32'(rsp_tdata[46:32]),
                                  32'(want.run_length));
               if (rsp_tlast !== want.image_done)
                  report_mismatch("image_done", 32'(rsp_tlast), 32'(want.image_done));
               if (rsp_tuser !== want.run_clamped)
                  report_mismatch("run_clamped", 32'(rsp_tuser), 32'(want.run_clamped));
            end
         end
         if (req_tvalid && req_tready) begin
            decode_word(req_tdata);
            words_taken <= words_taken + 1;
         end
         req_fired <= req_tvalid && req_tready;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            stuck_cycles <= 0;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $realtime, STUCK_LIMIT, expected_texels.size());
            $display("rle_rgb555_texture_decoder test failed");
            $finish;
         end
      end
   end

   // Sender: a word stays on the bus until it is taken; between words it may idle.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_words.pop_front();
         end else begin
            req_tvalid <= 1'b0;
            req_tdata <= 16'($urandom_range(0, 16'hFFFF));
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off while the sender keeps
   // offering words, so that both registers fill and the input side stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_used && words_taken >= HOLD_AT) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   task automatic queue_word(input logic [15:0] w);
      pending_words.push_back(w);
      words_issued++;
   endtask

   // Wait until every queued word is taken and every texel has come back, then a
   // little longer so that words giving no texel have left the pipeline as well.
   task automatic drain_decoder();
      while (pending_words.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_texels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic compressed);
      drain_decoder();
      csr_we <= 1'b1;
      csr_wdata <= compressed;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_raw(input int unsigned count);
      repeat (count) queue_word(16'($urandom_range(0, 16'hFFFF)));
   endtask

   // A well-formed compressed image with random content: two size words, then
   // literal blocks and runs, with the odd stray word mixed in. It stops when the
   // image should be complete or the word budget is spent.
   task automatic send_compressed(input int unsigned budget);
      int unsigned start;
      int unsigned pix;
      int unsigned n;
      logic [15:0] cnt;
      start = words_issued;
      pix = 0;
      queue_word(16'($urandom_range(0, 16'hFFFF)));
      queue_word(16'($urandom_range(0, 16'hFFFF)));
      while (pix < rletex_pkg::IMAGE_PIXELS && words_issued - start < budget) begin
         if ($urandom_range(0, 99) < 6) begin
            queue_word(16'($urandom_range(0, 16'hFFFF)));
         end else if ($urandom_range(0, 1) == 1) begin
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 8);
            cnt = 16'(65536 - n);
            queue_word(cnt);
            repeat (n) queue_word(16'($urandom_range(0, 16'hFFFF)));
            pix += n;
         end else begin
            case ($urandom_range(0, 9))
               0: cnt = 16'($urandom_range(0, 16'hFEFF));
               1: cnt = '0;
               default: cnt = 16'($urandom_range(1, 400));
            endcase
            queue_word(cnt);
            queue_word(16'($urandom_range(0, 16'hFFFF)));
            pix += 32'(cnt);
         end
      end
      // A stray word after the image end must be swallowed.
      if (pix >= rletex_pkg::IMAGE_PIXELS) queue_word(16'($urandom_range(0, 16'hFFFF)));
   endtask

   initial begin
      logic compressed;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Raw mode straight out of reset: black, all ones, bit 15 alone and its
      // complement, so that bit 15 is seen to be ignored.
      queue_word(16'h0000);
      queue_word(16'hFFFF);
      queue_word(16'h7FFF);
      queue_word(16'h8000);

      // Compressed image: size words, a single literal, a two-literal block, an
      // empty run, a run of one, and the largest run count, which must be clamped
      // and end the image. The words after it are ignored.
      write_mode(1'b1);
      queue_word(16'hFFFF);
      queue_word(16'h0000);
      queue_word(16'hFFFF);
      queue_word(16'h1234);
      queue_word(16'hFFFE);
      queue_word(16'hFFFF);
      queue_word(16'h8000);
      queue_word(16'h0000);
      queue_word(16'h7FFF);
      queue_word(16'h0001);
      queue_word(16'h2AAA);
      queue_word(16'hFEFF);
      queue_word(16'h5555);
      queue_word(16'hFF00);
      queue_word(16'h1234);

      // Writing the same mode again restarts the image. A run leaves two pixels
      // free, then a three-literal block: the last literal falls past the end.
      write_mode(1'b1);
      queue_word(16'h0000);
      queue_word(16'hFFFF);
      queue_word(16'h3FFE);
      queue_word(16'h4321);
      queue_word(16'hFFFD);
      queue_word(16'h03E0);
      queue_word(16'h7C00);
      queue_word(16'h001F);

      // A long stretch with no idling on either side, then normal idling with the
      // receiver's long hold-off falling inside the next raw phase.
      write_mode(1'b0);
      idle_pct = 0;
      send_raw(120);
      drain_decoder();
      idle_pct = 22;
      send_raw(200);

      while (words_issued < WORD_TARGET) begin
         compressed = ($urandom_range(0, 3) != 0);
         write_mode(compressed);
         if (compressed) begin
            send_compressed($urandom_range(30, 120));
         end else begin
            send_raw($urandom_range(20, 60));
         end
      end

      drain_decoder();
      if (mismatches == 0) begin
         $display("rle_rgb555_texture_decoder test passed");
      end else begin
         $display("rle_rgb555_texture_decoder test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
